/* hw/rtl/ipv4_flow_header_classifier_defines.svh */
// Assertion macros used by the classifier checker.
`ifndef IPV4_FLOW_HEADER_CLASSIFIER_DEFINES_SVH
`define IPV4_FLOW_HEADER_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define IFHC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define IFHC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/ifhc_pkg.sv */
// Types and constants of the IPv4 flow header classifier.
package ifhc_pkg;

   localparam int MAX_FRAME_BYTES = 16383;
   localparam int COUNT_W = $clog2(MAX_FRAME_BYTES + 1);

   typedef logic [COUNT_W-1:0] count_type;

   localparam count_type MAX_COUNT = count_type'(MAX_FRAME_BYTES);

   // minimum frame lengths for each check
   localparam count_type MIN_ETH_LEN      = count_type'(14);
   localparam count_type MIN_IP_LEN       = count_type'(34);
   localparam count_type MIN_UDP_LEN      = count_type'(42);
   localparam count_type MIN_TCP_LEN      = count_type'(54);
   localparam count_type MIN_ICMP_LEN     = count_type'(42);
   localparam count_type MIN_QUOTE_LEN    = count_type'(62);
   localparam count_type MIN_QUOTE_L4_LEN = count_type'(66);

   localparam logic [15:0] ETH_HDR_BYTES       = 16'd14;
   localparam logic [15:0] MIN_IP_TOTAL        = 16'd20;
   localparam logic [15:0] ETH_TYPE_IPV4       = 16'h0800;
   localparam logic [15:0] FRAG_MORE           = 16'h2000;
   localparam logic [15:0] FRAG_OFFSET_MASK    = 16'h1FFF;
   localparam logic [15:0] ICMP_PMTU_TYPE_CODE = 16'h0304;
   localparam logic [3:0]  IP_VERSION_4        = 4'd4;
   localparam logic [3:0]  IP_IHL_PLAIN        = 4'd5;
   localparam logic [7:0]  PROTO_ICMP          = 8'd1;
   localparam logic [7:0]  PROTO_TCP           = 8'd6;
   localparam logic [7:0]  PROTO_UDP           = 8'd17;
   localparam logic [7:0]  TCP_FLAG_SYN        = 8'h02;
   localparam logic [7:0]  TCP_FLAG_ACK        = 8'h10;

   localparam logic [1:0] VERDICT_FLOW = 2'd0;
   localparam logic [1:0] VERDICT_PASS = 2'd1;
   localparam logic [1:0] VERDICT_DROP = 2'd2;

   localparam logic [2:0] REASON_NONE     = 3'd0;
   localparam logic [2:0] REASON_SHORT    = 3'd1;
   localparam logic [2:0] REASON_VERSION  = 3'd2;
   localparam logic [2:0] REASON_OPTIONS  = 3'd3;
   localparam logic [2:0] REASON_FRAGMENT = 3'd4;

   typedef struct packed {
      logic [15:0] ether_type;
      logic [7:0]  version_ihl;
      logic [7:0]  tos_byte;
      logic [15:0] total_length;
      logic [15:0] fragment_word;
      logic [7:0]  ip_proto;
      logic [31:0] source_addr;
      logic [31:0] dest_addr;
      logic [31:0] l4_ports;
      logic [7:0]  tcp_flag_byte;
      logic [15:0] icmp_type_code;
      logic [7:0]  inner_version_ihl;
      logic [7:0]  inner_proto;
      logic [31:0] inner_source;
      logic [31:0] inner_dest;
      logic [31:0] inner_ports;
   } header_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [2:0]  drop_reason;
      logic [31:0] client_addr;
      logic [31:0] service_addr;
      logic [15:0] client_port;
      logic [15:0] service_port;
      logic [7:0]  protocol;
      logic        new_connection;
      logic [15:0] ip_length;
      logic [7:0]  type_of_service;
      logic        from_icmp;
   } result_type;

endpackage

/* hw/rtl/ipv4_flow_header_classifier.sv */
// Top level of the IPv4 flow header classifier.
// Throughput: one frame byte per cycle while req_stall is low, back to back, frames may follow with no gap.
// The last byte's verdict is registered into the output register (or the skid entry) and shows on rsp_valid.
// req_stall rises only while two verdicts wait (output register plus skid entry).
// Reset (synchronous, active high) clears the byte count, captured fields,
// icmp_pmtu_enable and the valid flags of both result slots.
module ipv4_flow_header_classifier import ifhc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // byte request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_end,
   // verdict channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_verdict,
   output logic [2:0]  rsp_drop_reason,
   output logic [31:0] rsp_client_addr,
   output logic [31:0] rsp_service_addr,
   output logic [15:0] rsp_client_port,
   output logic [15:0] rsp_service_port,
   output logic [7:0]  rsp_protocol,
   output logic        rsp_new_connection,
   output logic [15:0] rsp_ip_length,
   output logic [7:0]  rsp_type_of_service,
   output logic        rsp_from_icmp,
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_icmp_pmtu_enable
);

   logic       icmp_pmtu_enable_ff;
   logic       req_accept;
   logic       skid_full;
   header_type hdr_cap;
   count_type  count_cap;
   result_type decided;
   result_type rsp_result;

   // config writes are always accepted and registered
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         icmp_pmtu_enable_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         icmp_pmtu_enable_ff <= csr_icmp_pmtu_enable;
      end
   end

   // stall is a register: it only reflects a full skid slot
   assign req_stall  = skid_full;
   assign req_accept = req_valid && !req_stall;

   // captured view includes the byte being accepted, so the last
   // byte's fields feed the verdict in the same cycle
   ifhc_capture u_capture (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .req_data_byte (req_data_byte),
      .req_frame_end (req_frame_end),
      .hdr_cap       (hdr_cap),
      .count_cap     (count_cap)
   );

   ifhc_decide u_decide (
      .hdr              (hdr_cap),
      .frame_len        (count_cap),
      .icmp_pmtu_enable (icmp_pmtu_enable_ff),
      .result           (decided)
   );

   // one verdict per accepted last byte
   ifhc_out u_out (
      .clock       (clock),
      .reset       (reset),
      .push        (req_accept && req_frame_end),
      .push_result (decided),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_result  (rsp_result),
      .skid_full   (skid_full)
   );

   assign rsp_verdict         = rsp_result.verdict;
   assign rsp_drop_reason     = rsp_result.drop_reason;
   assign rsp_client_addr     = rsp_result.client_addr;
   assign rsp_service_addr    = rsp_result.service_addr;
   assign rsp_client_port     = rsp_result.client_port;
   assign rsp_service_port    = rsp_result.service_port;
   assign rsp_protocol        = rsp_result.protocol;
   assign rsp_new_connection  = rsp_result.new_connection;
   assign rsp_ip_length       = rsp_result.ip_length;
   assign rsp_type_of_service = rsp_result.type_of_service;
   assign rsp_from_icmp       = rsp_result.from_icmp;

endmodule

/* hw/rtl/ifhc_capture.sv */
// Byte counter and header field capture registers.
module ifhc_capture import ifhc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_accept,
   input  logic [7:0] req_data_byte,
   input  logic       req_frame_end,
   output header_type hdr_cap,
   output count_type  count_cap
);

   header_type hdr_ff;
   count_type  count_ff;
   count_type  pos;
   logic [7:0] b;

   assign pos = count_ff;
   assign b   = req_data_byte;

   // saturating count including the current byte
   assign count_cap = (count_ff < MAX_COUNT) ? count_ff + count_type'(1) : count_ff;

   always_comb begin
      hdr_cap = hdr_ff;
      if (pos >= count_type'(12) && pos <= count_type'(13)) begin
         hdr_cap.ether_type = {hdr_ff.ether_type[7:0], b};
      end else if (pos == count_type'(14)) begin
         hdr_cap.version_ihl = b;
      end else if (pos == count_type'(15)) begin
         hdr_cap.tos_byte = b;
      end else if (pos >= count_type'(16) && pos <= count_type'(17)) begin
         hdr_cap.total_length = {hdr_ff.total_length[7:0], b};
      end else if (pos >= count_type'(20) && pos <= count_type'(21)) begin
         hdr_cap.fragment_word = {hdr_ff.fragment_word[7:0], b};
      end else if (pos == count_type'(23)) begin
         hdr_cap.ip_proto = b;
      end else if (pos >= count_type'(26) && pos <= count_type'(29)) begin
         hdr_cap.source_addr = {hdr_ff.source_addr[23:0], b};
      end else if (pos >= count_type'(30) && pos <= count_type'(33)) begin
         hdr_cap.dest_addr = {hdr_ff.dest_addr[23:0], b};
      end else if (pos >= count_type'(42) && pos <= count_type'(65)) begin
         // ICMP quote area; TCP flags sit inside it as well
         if (pos == count_type'(42)) begin
            hdr_cap.inner_version_ihl = b;
         end else if (pos == count_type'(51)) begin
            hdr_cap.inner_proto = b;
         end else if (pos >= count_type'(54) && pos <= count_type'(57)) begin
            hdr_cap.inner_source = {hdr_ff.inner_source[23:0], b};
         end else if (pos >= count_type'(58) && pos <= count_type'(61)) begin
            hdr_cap.inner_dest = {hdr_ff.inner_dest[23:0], b};
         end else if (pos >= count_type'(62)) begin
            hdr_cap.inner_ports = {hdr_ff.inner_ports[23:0], b};
         end
         if (pos == count_type'(47)) begin
            hdr_cap.tcp_flag_byte = b;
         end
      end
      if (pos >= count_type'(34) && pos <= count_type'(37)) begin
         hdr_cap.l4_ports = {hdr_ff.l4_ports[23:0], b};
      end
      if (pos >= count_type'(34) && pos <= count_type'(35)) begin
         hdr_cap.icmp_type_code = {hdr_ff.icmp_type_code[7:0], b};
      end
   end

   // everything clears after the last byte of a frame
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff   <= '0;
         count_ff <= '0;
      end else if (req_accept) begin
         if (req_frame_end) begin
            hdr_ff   <= '0;
            count_ff <= '0;
         end else begin
            hdr_ff   <= hdr_cap;
            count_ff <= count_cap;
         end
      end
   end

endmodule

/* hw/rtl/ifhc_decide.sv */
// Verdict logic over the captured header of a finished frame.
module ifhc_decide import ifhc_pkg::*; (
   input  header_type hdr,
   input  count_type  frame_len,
   input  logic       icmp_pmtu_enable,
   output result_type result
);

   logic [16:0] ip_need;
   logic [16:0] len_ext;
   logic        is_tcp;
   logic        is_udp;
   logic        inner_l4;

   assign ip_need  = 17'(hdr.total_length) + 17'(ETH_HDR_BYTES);
   assign len_ext  = 17'(frame_len);
   assign is_tcp   = (hdr.ip_proto == PROTO_TCP);
   assign is_udp   = (hdr.ip_proto == PROTO_UDP);
   assign inner_l4 = (hdr.inner_proto == PROTO_TCP) || (hdr.inner_proto == PROTO_UDP);

   always_comb begin
      result         = '0;
      result.verdict = VERDICT_DROP;
      priority if (frame_len < MIN_ETH_LEN) begin
         result.drop_reason = REASON_SHORT;
      end else if (hdr.ether_type != ETH_TYPE_IPV4) begin
         result.verdict = VERDICT_PASS;
      end else if (frame_len < MIN_IP_LEN) begin
         result.drop_reason = REASON_SHORT;
      end else if (hdr.version_ihl[7:4] != IP_VERSION_4) begin
         result.drop_reason = REASON_VERSION;
      end else if (hdr.version_ihl[3:0] != IP_IHL_PLAIN) begin
         result.drop_reason = REASON_OPTIONS;
      end else if ((hdr.fragment_word & (FRAG_MORE | FRAG_OFFSET_MASK)) != 16'd0) begin
         result.drop_reason = REASON_FRAGMENT;
      end else if (hdr.total_length < MIN_IP_TOTAL || ip_need > len_ext) begin
         result.drop_reason = REASON_SHORT;
      end else if (is_tcp || is_udp) begin
         if (frame_len < (is_tcp ? MIN_TCP_LEN : MIN_UDP_LEN)) begin
            result.drop_reason = REASON_SHORT;
         end else begin
            result.verdict         = VERDICT_FLOW;
            result.client_addr     = hdr.source_addr;
            result.service_addr    = hdr.dest_addr;
            result.client_port     = hdr.l4_ports[31:16];
            result.service_port    = hdr.l4_ports[15:0];
            result.protocol        = hdr.ip_proto;
            result.new_connection  = is_tcp && ((hdr.tcp_flag_byte & TCP_FLAG_SYN) != 8'd0)
                                     && ((hdr.tcp_flag_byte & TCP_FLAG_ACK) == 8'd0);
            result.ip_length       = hdr.total_length;
            result.type_of_service = hdr.tos_byte;
         end
      end else if (hdr.ip_proto != PROTO_ICMP) begin
         result.verdict = VERDICT_PASS;
      end else if (frame_len < MIN_ICMP_LEN) begin
         result.drop_reason = REASON_SHORT;
      end else if (!icmp_pmtu_enable || hdr.icmp_type_code != ICMP_PMTU_TYPE_CODE) begin
         result.verdict = VERDICT_PASS;
      end else if (frame_len < MIN_QUOTE_LEN) begin
         result.drop_reason = REASON_SHORT;
      end else if (hdr.inner_version_ihl[3:0] != IP_IHL_PLAIN || !inner_l4) begin
         result.verdict = VERDICT_PASS;
      end else if (frame_len < MIN_QUOTE_L4_LEN) begin
         result.drop_reason = REASON_SHORT;
      end else begin
         // quoted packet went service to client: swap it back
         result.verdict         = VERDICT_FLOW;
         result.client_addr     = hdr.inner_dest;
         result.service_addr    = hdr.inner_source;
         result.client_port     = hdr.inner_ports[15:0];
         result.service_port    = hdr.inner_ports[31:16];
         result.protocol        = hdr.inner_proto;
         result.ip_length       = hdr.total_length;
         result.type_of_service = hdr.tos_byte;
         result.from_icmp       = 1'b1;
      end
   end

endmodule

/* hw/rtl/ifhc_out.sv */
// Result register with a one-entry skid buffer.
module ifhc_out import ifhc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_result,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output result_type rsp_result,
   output logic       skid_full
);

   logic       main_valid_ff;
   result_type main_ff;
   logic       skid_valid_ff;
   result_type skid_ff;
   logic       pop;

   assign pop        = main_valid_ff && !rsp_stall;
   assign rsp_valid  = main_valid_ff;
   assign rsp_result = main_ff;
   assign skid_full  = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // input is stalled while the skid holds a result
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_ff <= push_result;
         end else begin
            skid_ff <= push_result;
         end
      end
   end

endmodule

/* hw/rtl/ifhc_checker.sv */
// Port-level checker of the classifier and its bind.
`include "ipv4_flow_header_classifier_defines.svh"

module ifhc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_frame_end,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_verdict,
   input logic [31:0] rsp_client_addr
);

   `IFHC_ASSERT_NEXT(a_rsp_holds, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_verdict) && $stable(rsp_client_addr), "stalled verdict changed")
   `IFHC_ASSERT_NEXT(a_no_spurious, !rsp_valid && !(req_valid && !req_stall && req_frame_end), !rsp_valid, "verdict without a frame end")
   `IFHC_ASSERT_NEXT(a_end_gives_rsp, req_valid && !req_stall && req_frame_end && !rsp_valid, rsp_valid, "frame end gave no verdict")
   `IFHC_ASSERT_NOW(a_stall_needs_rsp, req_stall, rsp_valid, "request stalled with no verdict waiting")

endmodule

bind ipv4_flow_header_classifier ifhc_checker u_ifhc_checker (.*);
